/* design/rgse_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and arithmetic helpers for the grey-scale Sobel edge core.
// No dependencies; imported by rgb_grey_sobel_edge_core.
package rgse_pkg;

    localparam int PIX_W = 8;
    localparam int CFG_W = 12;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W = 11;
    localparam int DEF_MAX_WIDTH = 2048;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 12'd2048;

    localparam logic [7:0] B_WEIGHT = 8'd18;
    localparam logic [7:0] G_WEIGHT = 8'd183;
    localparam logic [7:0] R_WEIGHT = 8'd55;

    // 3x3 grey window, row-major, tap 0 is the top-left corner.
    typedef logic [8:0][PIX_W-1:0] window_t;

    // Control that travels with a pixel down the pipeline.
    typedef struct packed {
        logic produce;
        logic row_end;
        logic frame_end;
    } pix_ctl_t;

    function automatic logic [PIX_W-1:0] grey_of(input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] r);
        logic [15:0] acc;
        acc = 16'(B_WEIGHT) * 16'(b) + 16'(G_WEIGHT) * 16'(g) + 16'(R_WEIGHT) * 16'(r);
        return acc[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] sobel_mag(input window_t t);
        logic [9:0]  xp;
        logic [9:0]  xn;
        logic [9:0]  yp;
        logic [9:0]  yn;
        logic [9:0]  ax;
        logic [9:0]  ay;
        logic [10:0] mag;
        xp  = 10'(t[2]) + {1'b0, t[5], 1'b0} + 10'(t[8]);
        xn  = 10'(t[0]) + {1'b0, t[3], 1'b0} + 10'(t[6]);
        yp  = 10'(t[0]) + {1'b0, t[1], 1'b0} + 10'(t[2]);
        yn  = 10'(t[6]) + {1'b0, t[7], 1'b0} + 10'(t[8]);
        ax  = (xp >= xn) ? (xp - xn) : (xn - xp);
        ay  = (yp >= yn) ? (yp - yn) : (yn - yp);
        mag = 11'(ax) + 11'(ay);
        return (mag > 11'd255) ? 8'd255 : mag[7:0];
    endfunction

endpackage

/* design/rgb_grey_sobel_edge_core.sv */
`timescale 1ns / 1ps
// Top level of the colour-to-grey Sobel edge core: line memories, window and output queue.
// Depends on rgse_pkg.
//
//  Channel   Direction  Transfer on              Payload
//  s_        in         s_tvalid & s_tready      tdata: blue, green, red
//  m_        out        m_tvalid & m_tready      tdata: edge_magnitude, tlast: row_end,
//                                                tuser: frame_end
//  cfg_      in         cfg_valid & cfg_ready    cfg_index, cfg_wdata
//
// One pixel is taken per cycle while s_tready is high; results pass stages 1 and 2 to the queue.
// The rate is set by the single read-modify-write of the two line memories per pixel.
// After reset a clearing pass zeroes every entry of the line memories; s_tready is low
// throughout and configuration writes are taken as usual.
// A four-entry output queue absorbs stalls on m_; besides the clearing pass, s_tready drops only
// when the queue plus the pixels still in the pipeline would fill it.
module rgb_grey_sobel_edge_core #(
    parameter int MAX_WIDTH = rgse_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [23:0]                    s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rgse_pkg::PIX_W-1:0]     m_tdata,   // [7:0] edge_magnitude
    output logic                           m_tlast,
    output logic                           m_tuser,   // [0] frame_end
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rgse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgse_pkg::CFG_W-1:0]     cfg_wdata
);
    import rgse_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCMP_W = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = 2;
    localparam int ENTRY_W = PIX_W + 2;

    typedef enum logic {ST_CLEAR, ST_RUN} state_t;

    state_t             state_reg;
    logic [COL_W-1:0]   clr_addr_reg;

    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;

    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;

    logic [WCMP_W-1:0]  fw_ext;
    logic [WCMP_W-1:0]  width_eff;
    logic [WCMP_W-1:0]  col_plus;
    logic [CFG_W-1:0]   height_eff;
    logic [CFG_W-1:0]   row_plus;
    logic               last_col;
    logic               last_row;
    logic               s_xfer;

    // Stage 1: memory read data is valid, grey is formed and written back.
    logic               v1_reg;
    logic [COL_W-1:0]   addr1_reg;
    logic [23:0]        rgb1_reg;
    pix_ctl_t           ctl1_reg;
    logic [PIX_W-1:0]   grey1;

    // Stage 2: window holds this pixel's neighbourhood.
    logic               v2_reg;
    pix_ctl_t           ctl2_reg;
    window_t            window_reg;
    window_t            window_next;

    logic [PIX_W-1:0]   upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   upper_rd_reg;
    logic [PIX_W-1:0]   middle_rd_reg;
    logic               mem_we;
    logic [COL_W-1:0]   mem_waddr;
    logic [PIX_W-1:0]   upper_wdata;
    logic [PIX_W-1:0]   middle_wdata;

    logic [ENTRY_W-1:0] fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   cnt_reg;
    logic [FIFO_AW+1:0] committed;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] head;

    // Clearing sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + COL_W'(1);
                    if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    state_reg <= ST_RUN;
                end
                default: begin
                    state_reg <= ST_CLEAR;
                end
            endcase
        end
    end

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Position counters and end-of-row / end-of-frame decisions at the input.
    always_comb begin
        fw_ext = WCMP_W'(frame_width_reg);
        if (fw_ext < WCMP_W'(MIN_DIM)) begin
            width_eff = WCMP_W'(MIN_DIM);
        end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            width_eff = fw_ext;
        end
        if (frame_height_reg < MIN_DIM) begin
            height_eff = MIN_DIM;
        end else if (frame_height_reg > HEIGHT_LIMIT) begin
            height_eff = HEIGHT_LIMIT;
        end else begin
            height_eff = frame_height_reg;
        end
        col_plus = WCMP_W'(col_reg) + WCMP_W'(1);
        row_plus = CFG_W'(row_reg) + CFG_W'(1);
        last_col = (col_plus >= width_eff);
        last_row = (row_plus >= height_eff);
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_plus[ROW_W-1:0];
        end else begin
            col_next = col_plus[COL_W-1:0];
            row_next = row_reg;
        end
    end

    assign committed = (FIFO_AW+2)'(cnt_reg) + (FIFO_AW+2)'(v1_reg) + (FIFO_AW+2)'(v2_reg);
    assign s_tready  = (state_reg == ST_RUN) && (committed < (FIFO_AW+2)'(FIFO_DEPTH));
    assign s_xfer    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            v1_reg <= s_xfer;
            v2_reg <= v1_reg;
            if (s_xfer) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            addr1_reg          <= col_reg;
            rgb1_reg           <= s_tdata;
            ctl1_reg.produce   <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            ctl1_reg.row_end   <= last_col;
            ctl1_reg.frame_end <= last_col && last_row;
        end
        if (v1_reg) begin
            ctl2_reg   <= ctl1_reg;
            window_reg <= window_next;
        end
    end

    // Line memories: read at the transfer, written back in the following cycle. Consecutive pixels
    // never share a column, so a read never meets a pending write to the same entry.
    assign grey1 = grey_of(rgb1_reg[7:0], rgb1_reg[15:8], rgb1_reg[23:16]);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            mem_we       = 1'b1;
            mem_waddr    = clr_addr_reg;
            upper_wdata  = '0;
            middle_wdata = '0;
        end else begin
            mem_we       = v1_reg;
            mem_waddr    = addr1_reg;
            upper_wdata  = middle_rd_reg;
            middle_wdata = grey1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            upper_mem[mem_waddr]  <= upper_wdata;
            middle_mem[mem_waddr] <= middle_wdata;
        end
        if (s_xfer) begin
            upper_rd_reg  <= upper_mem[col_reg];
            middle_rd_reg <= middle_mem[col_reg];
        end
    end

    // The window moves one column left; the new right column is top, middle and current grey.
    always_comb begin
        window_next[0] = window_reg[1];
        window_next[1] = window_reg[2];
        window_next[2] = upper_rd_reg;
        window_next[3] = window_reg[4];
        window_next[4] = window_reg[5];
        window_next[5] = middle_rd_reg;
        window_next[6] = window_reg[7];
        window_next[7] = window_reg[8];
        window_next[8] = grey1;
    end

    // Output queue.
    assign push = v2_reg && ctl2_reg.produce;
    assign pop  = m_tvalid && m_tready;
    assign head = fifo_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {ctl2_reg.frame_end, ctl2_reg.row_end, sobel_mag(window_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + (FIFO_AW+1)'(1);
                2'b01:   cnt_reg <= cnt_reg - (FIFO_AW+1)'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = head[PIX_W-1:0];
    assign m_tlast  = head[PIX_W];
    assign m_tuser  = head[PIX_W+1];

endmodule

/* design/rgse_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for rgb_grey_sobel_edge_core, attached by the bind at the end.
// Depends only on the top level's ports.
module rgse_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Reset always starts the clearing pass, so no pixel is taken on the next cycle.
    a_clear_after_reset: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input ready straight after reset");

    // The end of a frame is always also the end of a row.
    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end without row end");

    // A result only appears after a pixel transfer, through the core's pipeline and output queue.
    a_result_follows_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result without a matching pixel transfer");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                     && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind rgb_grey_sobel_edge_core rgse_checker u_rgse_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rgb_grey_sobel_edge_core: streams BGR pixels in, predicts each
// edge magnitude with its own grey/line-store/window model and compares every output transfer.
// Depends on rgse_pkg and rgb_grey_sobel_edge_core.
module tb;

    import rgse_pkg::*;

    localparam int DRAIN_CYCLES = 10;
    localparam int FRAME_ALL = 32'h7fff_ffff;
    localparam int LINE_DEPTH = DEF_MAX_WIDTH;

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // 5x5 frame of channel extremes, black/white steps and near-flat grey, as {red, green, blue}.
    localparam logic [23:0] DIRECTED_PIXELS [25] = '{
        24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFFFF,
        24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h000000,
        24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
        24'h808080, 24'h808080, 24'h808080, 24'h7F7F7F, 24'h808080
    };

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             row_end;
        logic             frame_end;
    } edge_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [PIX_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow copy of the block's sizes and image state.
    logic [CFG_W-1:0] width_setting = RESET_WIDTH;
    logic [CFG_W-1:0] height_setting = RESET_HEIGHT;
    logic [7:0]       upper_line [LINE_DEPTH] = '{default: 8'd0};
    logic [7:0]       middle_line [LINE_DEPTH] = '{default: 8'd0};
    int               grey_window [9] = '{default: 0};
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    edge_result_t results_due [$];
    int           fail_count = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;

    // Long receiver hold-off: the test toggles hold_go, the receiver counts the cycles.
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_len = 0;
    int   hold_left = 0;

    rgb_grey_sobel_edge_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void predict_pixel(input logic [23:0] pix);
        int w;
        int h;
        int grey;
        int top;
        int mid;
        int gx;
        int gy;
        int mag;
        bit last_col;
        bit last_row;
        edge_result_t res;
        w = (width_setting < MIN_DIM) ? 3 :
            (width_setting > LINE_DEPTH) ? LINE_DEPTH : int'(width_setting);
        h = (height_setting < MIN_DIM) ? 3 :
            (height_setting > HEIGHT_LIMIT) ? int'(HEIGHT_LIMIT) : int'(height_setting);
        grey = (int'(B_WEIGHT) * int'(pix[7:0]) + int'(G_WEIGHT) * int'(pix[15:8])
                + int'(R_WEIGHT) * int'(pix[23:16])) >> 8;
        // The column never reaches the line depth: the width is clamped to it.
        top = int'(upper_line[col_pos]);
        mid = int'(middle_line[col_pos]);
        upper_line[col_pos] = mid[7:0];
        middle_line[col_pos] = grey[7:0];
        for (int i = 0; i < 9; i += 3) begin
            grey_window[i] = grey_window[i + 1];
            grey_window[i + 1] = grey_window[i + 2];
        end
        grey_window[2] = top;
        grey_window[5] = mid;
        grey_window[8] = grey;
        last_col = (col_pos + 1 >= w);
        last_row = (row_pos + 1 >= h);
        if (row_pos >= 2 && col_pos >= 2) begin
            gx = (grey_window[2] + 2 * grey_window[5] + grey_window[8])
               - (grey_window[0] + 2 * grey_window[3] + grey_window[6]);
            gy = (grey_window[0] + 2 * grey_window[1] + grey_window[2])
               - (grey_window[6] + 2 * grey_window[7] + grey_window[8]);
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            res.magnitude = (mag > 255) ? 8'd255 : mag[7:0];
            res.row_end = last_col;
            res.frame_end = last_col && last_row;
            results_due.push_back(res);
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic logic [23:0] pick_pixel(input bit gentle, input logic [7:0] base);
        if (gentle) begin
            return {base + 8'($urandom_range(7)), base + 8'($urandom_range(7)),
                    base + 8'($urandom_range(7))};
        end
        return 24'($urandom());
    endfunction

    task automatic send_pixel(input logic [23:0] pix);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pixel(pix);
    endtask

    // Sends until the frame wraps or the limit is reached; returns how many were sent.
    task automatic send_to_frame_start(input int limit, output int count);
        bit gentle;
        logic [7:0] base;
        gentle = ($urandom_range(3) == 0);
        base = 8'($urandom_range(248));
        count = 0;
        do begin
            send_pixel(pick_pixel(gentle, base));
            count++;
        end while (!(col_pos == 0 && row_pos == 0) && count < limit);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_FRAME_WIDTH) begin
            width_setting = value;
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_setting = value;
        end
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    // Reset sizes: part of a 640-pixel row, then the width is cut to 3 for six more rows with
    // no frame end, then the height is cut to end the frame.
    task automatic test_reset_size();
        int sent;
        send_gap_pct = 8;
        recv_stall_pct = 78;
        repeat (20) send_pixel(pick_pixel(1'b0, 8'd0));
        drain_results();
        write_register(REG_FRAME_WIDTH, 12'd3);
        repeat (18) send_pixel(pick_pixel(1'b0, 8'd0));
        drain_results();
        write_register(REG_FRAME_HEIGHT, 12'd3);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
    endtask

    task automatic test_directed_pixels();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_frame(12'd5, 12'd5);
        foreach (DIRECTED_PIXELS[i]) send_pixel(DIRECTED_PIXELS[i]);
        drain_results();
    endtask

    task automatic test_unknown_register();
        int sent;
        set_frame(12'd5, 12'd4);
        write_register(REG_SPARE_A, 12'h003);
        write_register(REG_SPARE_B, 12'hFFF);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
    endtask

    // Sizes below the minimum and above the maximum. The large sizes run well past any small
    // size, then a resize part-way ends the row or the frame.
    task automatic test_size_clamps();
        int sent;
        send_gap_pct = 78;
        recv_stall_pct = 8;
        set_frame(12'd0, 12'd1);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
        set_frame(12'd2, 12'd0);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
        set_frame(12'hFFF, 12'd2);
        send_to_frame_start(40, sent);
        drain_results();
        write_register(REG_FRAME_WIDTH, 12'd3);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
        set_frame(12'd1, 12'hFFF);
        send_to_frame_start(40, sent);
        drain_results();
        write_register(REG_FRAME_HEIGHT, 12'd3);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
    endtask

    // Shrinking the width past the current column and the height past the current row.
    task automatic test_midframe_resize();
        int sent;
        send_gap_pct = 8;
        recv_stall_pct = 78;
        set_frame(12'd8, 12'd6);
        send_to_frame_start(20, sent);
        drain_results();
        write_register(REG_FRAME_WIDTH, 12'd3);
        send_to_frame_start(7, sent);
        drain_results();
        write_register(REG_FRAME_HEIGHT, 12'd3);
        send_to_frame_start(FRAME_ALL, sent);
        drain_results();
    endtask

    task automatic test_output_backpressure();
        int sent;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_frame(12'd6, 12'd6);
        hold_len <= 400;
        hold_go <= ~hold_go;
        repeat (3) send_to_frame_start(FRAME_ALL, sent);
        drain_results();
    endtask

    task automatic reconfigure_random();
        int pick;
        if ($urandom_range(7) == 0) begin
            write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom()));
        end
        if ($urandom_range(3) != 0) begin
            pick = $urandom_range(99);
            write_register(REG_FRAME_WIDTH, (pick < 80) ? 12'($urandom_range(3, 10)) :
                                            (pick < 90) ? 12'($urandom_range(0, 2)) :
                                                          12'($urandom_range(11, 40)));
        end
        if ($urandom_range(3) != 0) begin
            pick = $urandom_range(99);
            write_register(REG_FRAME_HEIGHT, (pick < 85) ? 12'($urandom_range(3, 6)) :
                                                           12'($urandom_range(0, 2)));
        end
    endtask

    // Mostly whole frames of random size; now and then a frame is cut short and resized mid-way.
    task automatic test_random_stream(input int send_pct, input int recv_pct, input int n_pixels);
        int sent;
        int count;
        int limit;
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < n_pixels) begin
            drain_results();
            reconfigure_random();
            limit = ($urandom_range(5) == 0) ? $urandom_range(1, 20) : FRAME_ALL;
            send_to_frame_start(limit, count);
            sent += count;
        end
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= hold_len;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        edge_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (results_due.size() == 0) begin
                $error("output transfer with no result expected: edge_magnitude %0d", m_tdata);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (m_tdata !== want.magnitude) begin
                    $error("edge_magnitude: expected %0d, got %0d", want.magnitude, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.row_end) begin
                    $error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_size();
        test_directed_pixels();
        test_unknown_register();
        test_size_clamps();
        test_midframe_resize();
        test_output_backpressure();
        test_random_stream(8, 78, 200);
        test_random_stream(78, 8, 200);
        test_random_stream(0, 0, 120);
        drain_results();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/rgse_pkg.sv
design/rgb_grey_sobel_edge_core.sv
design/rgse_checker.sv
verif/tb.sv
